/* src/rbn_pkg.sv */
// Package for the anti-aliased ribbon pixel shader.
// Holds request/response structs, register indexes, pixel roles and widths.
// No dependencies.
package rbn_pkg;

    localparam int COORD_W         = 19;
    localparam int COLOR_W         = 24;
    localparam int PIX_W           = 11;
    localparam int RGB565_W        = 16;
    localparam int QUO_W           = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int SCREEN_WIDTH    = 480;
    localparam int SCREEN_HEIGHT   = 272;
    localparam int COORD_FRAC_BITS = 8;

    localparam logic [CFG_IDX_W-1:0] REG_START_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_TOP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_BOT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_TOP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_BOT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_COL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_END_COL   = 3'd7;

    localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFFFFFF;

    typedef enum logic [1:0] {
        ROLE_OUT  = 2'd0,
        ROLE_TOP  = 2'd1,
        ROLE_FILL = 2'd2,
        ROLE_BOT  = 2'd3
    } t_role;

    typedef struct packed {
        logic [PIX_W-1:0]    pixel_x;
        logic [PIX_W-1:0]    pixel_y;
        logic [RGB565_W-1:0] background_pixel;
    } t_in_req;

    typedef struct packed {
        logic [RGB565_W-1:0] new_pixel;
        logic                write_enable;
        logic [1:0]          pixel_role;
    } t_out_req;

    // Per-pixel context that rides along the pipeline.
    typedef struct packed {
        logic [PIX_W-1:0]    y;
        logic [RGB565_W-1:0] bg;
        logic                in_span;
        logic                t_zero;
        logic                t_one;
    } t_ctx;

endpackage

/* src/rbn_div_stage.sv */
// One registered stage of the restoring divider: two quotient bits per stage.
// Depends on rbn_pkg for the quotient width.
module rbn_div_stage #(
    parameter int DW = rbn_pkg::COORD_W
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [DW-1:0]            i_rem,
    input  logic [rbn_pkg::QUO_W-1:0] i_quo,
    input  logic [DW-1:0]            i_div,
    output logic [DW-1:0]            o_rem,
    output logic [rbn_pkg::QUO_W-1:0] o_quo
);
    logic [DW:0]   r2a, r2b;
    logic [DW-1:0] ra, rb;
    logic          ba, bb;
    logic [DW-1:0] r_rem;
    logic [rbn_pkg::QUO_W-1:0] r_quo;

    // The remainder stays below the divisor, so each difference fits DW bits.
    always_comb begin
        r2a = {i_rem, 1'b0};
        ba  = r2a >= {1'b0, i_div};
        ra  = ba ? DW'(r2a - {1'b0, i_div}) : DW'(r2a);
        r2b = {ra, 1'b0};
        bb  = r2b >= {1'b0, i_div};
        rb  = bb ? DW'(r2b - {1'b0, i_div}) : DW'(r2b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= rb;
            r_quo <= {i_quo[rbn_pkg::QUO_W-3:0], ba, bb};
        end
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;
endmodule

/* src/aa_ribbon_pixel_shader_core.sv */
// Ribbon pixel shader: 14-stage pipeline, one prep stage, eight divider stages
// (two bits each), then t-square, ease and lerp, edge height, role and blend stages.
// Throughput is one pixel per cycle while the output is not stalled, set by the
// pipelined divider. Bubbles collapse, so a stalled output still takes input while
// any stage is empty. Synchronous active-low reset clears the valid bits and loads the
// configuration registers with zero coordinates and white colors.
module aa_ribbon_pixel_shader_core #(
    parameter int SCREEN_WIDTH    = rbn_pkg::SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT   = rbn_pkg::SCREEN_HEIGHT,
    parameter int COORD_FRAC_BITS = rbn_pkg::COORD_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  rbn_pkg::t_in_req                  i_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output rbn_pkg::t_out_req                 o_out,
    input  logic                              i_cfg_we,
    input  logic [rbn_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rbn_pkg::COLOR_W-1:0]       i_cfg_data
);
    localparam int CW   = rbn_pkg::COORD_W;
    localparam int F    = COORD_FRAC_BITS;
    localparam int PXW  = rbn_pkg::PIX_W + F;
    localparam int SW   = ((PXW > CW) ? PXW : CW) + 1;
    localparam int HW   = CW + 16;
    localparam int SH   = F + 16;
    localparam int IW   = CW - F;
    localparam int YW   = (IW > rbn_pkg::PIX_W) ? IW : rbn_pkg::PIX_W;
    localparam int NDIV = 8;
    localparam int NST  = NDIV + 6;
    localparam int S_E1 = NDIV + 1;
    localparam logic [CW:0] HALF = (CW+1)'(1) << (F - 1);

    // Configuration registers.
    logic [CW-1:0] r_start_x, r_end_x, r_st_top, r_st_bot, r_en_top, r_en_bot;
    logic [rbn_pkg::COLOR_W-1:0] r_col0, r_col1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_end_x   <= '0;
            r_st_top  <= '0;
            r_st_bot  <= '0;
            r_en_top  <= '0;
            r_en_bot  <= '0;
            r_col0    <= rbn_pkg::COLOR_RESET;
            r_col1    <= rbn_pkg::COLOR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rbn_pkg::REG_START_X:   r_start_x <= i_cfg_data[CW-1:0];
                rbn_pkg::REG_END_X:     r_end_x   <= i_cfg_data[CW-1:0];
                rbn_pkg::REG_START_TOP: r_st_top  <= i_cfg_data[CW-1:0];
                rbn_pkg::REG_START_BOT: r_st_bot  <= i_cfg_data[CW-1:0];
                rbn_pkg::REG_END_TOP:   r_en_top  <= i_cfg_data[CW-1:0];
                rbn_pkg::REG_END_BOT:   r_en_bot  <= i_cfg_data[CW-1:0];
                rbn_pkg::REG_START_COL: r_col0    <= i_cfg_data;
                rbn_pkg::REG_END_COL:   r_col1    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control: a stage loads when it is empty or its successor loads.
    logic [NST-1:0] r_v;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = !r_v[NST-1] || !i_stall;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[NST-1];

    // Prep stage: column span test, clip and divider set-up.
    logic [CW-1:0] dspan;
    logic [CW:0]   lo, hi, x_e;
    logic [SW-1:0] px_e, st_e, diff;
    rbn_pkg::t_ctx prep_ctx;

    assign dspan = r_end_x - r_start_x;

    always_comb begin
        lo   = (({1'b0, r_start_x}) + HALF) >> F;
        hi   = (({1'b0, r_end_x}) + HALF) >> F;
        x_e  = (CW+1)'(i_in.pixel_x);
        px_e = SW'({i_in.pixel_x, {F{1'b0}}});
        st_e = SW'(r_start_x);
        diff = px_e - st_e;
        prep_ctx.y       = i_in.pixel_y;
        prep_ctx.bg      = i_in.background_pixel;
        prep_ctx.in_span = (r_end_x > r_start_x) && (x_e >= lo) && (x_e <= hi) &&
                           ({1'b0, i_in.pixel_x} < 12'(SCREEN_WIDTH)) &&
                           ({1'b0, i_in.pixel_y} < 12'(SCREEN_HEIGHT));
        prep_ctx.t_zero  = !(px_e > st_e);
        prep_ctx.t_one   = (px_e > st_e) && (diff >= SW'(dspan));
    end

    rbn_pkg::t_ctx                 r_ctx [0:NDIV];
    logic [CW-1:0]                 rem_q [0:NDIV];
    logic [rbn_pkg::QUO_W-1:0]     quo_q [0:NDIV];
    logic [CW-1:0]                 r_rem0;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_ctx[0] <= prep_ctx;
            r_rem0   <= diff[CW-1:0];
        end
    end

    assign rem_q[0] = r_rem0;
    assign quo_q[0] = '0;

    for (genvar g = 1; g <= NDIV; g++) begin : g_div
        rbn_div_stage #(.DW(CW)) u_div (
            .i_clk (i_clk),
            .i_en  (en[g]),
            .i_rem (rem_q[g-1]),
            .i_quo (quo_q[g-1]),
            .i_div (dspan),
            .o_rem (rem_q[g]),
            .o_quo (quo_q[g])
        );
        always_ff @(posedge i_clk) begin
            if (en[g]) begin
                r_ctx[g] <= r_ctx[g-1];
            end
        end
    end

    // E1: final t and its square.
    logic [16:0] t_val;
    logic [33:0] t_sq;
    logic [16:0] r_e1_t, r_e1_t2;
    rbn_pkg::t_ctx r_e1_ctx;

    always_comb begin
        if (r_ctx[NDIV].t_zero) begin
            t_val = '0;
        end else if (r_ctx[NDIV].t_one) begin
            t_val = 17'h10000;
        end else begin
            t_val = {1'b0, quo_q[NDIV]};
        end
        t_sq = t_val * t_val;
    end

    always_ff @(posedge i_clk) begin
        if (en[S_E1]) begin
            r_e1_t   <= t_val;
            r_e1_t2  <= t_sq[32:16];
            r_e1_ctx <= r_ctx[NDIV];
        end
    end

    // E2: smoothstep ease and color lerp.
    logic [17:0]       ease_k;
    logic [34:0]       ease_p;
    logic [2:0][7:0]   lerp_c;
    logic [16:0]       r_e2_e;
    logic [2:0][7:0]   r_e2_rgb;
    rbn_pkg::t_ctx     r_e2_ctx;

    always_comb begin
        logic signed [8:0]  cd;
        logic signed [25:0] lp;
        ease_k = 18'd196608 - {r_e1_t, 1'b0};
        ease_p = r_e1_t2 * ease_k;
        for (int c = 0; c < 3; c++) begin
            cd = $signed({1'b0, r_col1[c*8 +: 8]}) - $signed({1'b0, r_col0[c*8 +: 8]});
            lp = $signed({1'b0, r_e1_t[15:0]}) * cd;
            lp = lp + $signed({2'b00, r_col0[c*8 +: 8], 16'h0000});
            if (r_e1_t[16]) begin
                lerp_c[c] = r_col1[c*8 +: 8];
            end else begin
                lerp_c[c] = lp[23:16];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_E1+1]) begin
            r_e2_e   <= ease_p[32:16];
            r_e2_rgb <= lerp_c;
            r_e2_ctx <= r_e1_ctx;
        end
    end

    // E3: both edge heights and the RGB565 foreground.
    function automatic logic [HW-1:0] edge_y(input logic [CW-1:0] p0,
                                             input logic [CW-1:0] p3,
                                             input logic [16:0] e);
        logic signed [CW:0]     d;
        logic signed [CW+18:0]  v;
        d = $signed({1'b0, p3}) - $signed({1'b0, p0});
        v = (CW+19)'(d * $signed({1'b0, e}));
        v = v + $signed((CW+19)'({p0, 16'h0000}));
        if (v < 0) begin
            v = '0;
        end
        return v[HW-1:0];
    endfunction

    logic [HW-1:0] r_e3_top, r_e3_bot;
    logic [15:0]   r_e3_fg;
    rbn_pkg::t_ctx r_e3_ctx;

    always_ff @(posedge i_clk) begin
        if (en[S_E1+2]) begin
            r_e3_top <= edge_y(r_st_top, r_en_top, r_e2_e);
            r_e3_bot <= edge_y(r_st_bot, r_en_bot, r_e2_e);
            r_e3_fg  <= {r_e2_rgb[2][7:3], r_e2_rgb[1][7:2], r_e2_rgb[0][7:3]};
            r_e3_ctx <= r_e2_ctx;
        end
    end

    // E4: row classification and coverage.
    logic [HW-1:0]  e_lo, e_hi;
    logic [YW-1:0]  yt, yb, yp;
    logic [SH+7:0]  ct, cb;
    rbn_pkg::t_role n_role;
    logic [7:0]     n_alpha;
    rbn_pkg::t_role r_e4_role;
    logic [7:0]     r_e4_alpha;
    logic [15:0]    r_e4_fg, r_e4_bg;

    always_comb begin
        if (r_e3_top > r_e3_bot) begin
            e_lo = r_e3_bot;
            e_hi = r_e3_top;
        end else begin
            e_lo = r_e3_top;
            e_hi = r_e3_bot;
        end
        yt = YW'(e_lo[HW-1:SH]);
        yb = YW'(e_hi[HW-1:SH]);
        yp = YW'(r_e3_ctx.y);
        ct = {e_lo[SH-1:0], 8'h00} - (SH+8)'(e_lo[SH-1:0]);
        cb = {e_hi[SH-1:0], 8'h00} - (SH+8)'(e_hi[SH-1:0]);
        priority if (!r_e3_ctx.in_span) begin
            n_role  = rbn_pkg::ROLE_OUT;
            n_alpha = '0;
        end else if (yp == yt) begin
            n_role  = rbn_pkg::ROLE_TOP;
            n_alpha = 8'd255 - ct[SH+7:SH];
        end else if (yp > yt && yp < yb) begin
            n_role  = rbn_pkg::ROLE_FILL;
            n_alpha = 8'd255;
        end else if (yp == yb && yb > yt) begin
            n_role  = rbn_pkg::ROLE_BOT;
            n_alpha = cb[SH+7:SH];
        end else begin
            n_role  = rbn_pkg::ROLE_OUT;
            n_alpha = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_E1+3]) begin
            r_e4_role  <= n_role;
            r_e4_alpha <= n_alpha;
            r_e4_fg    <= r_e3_fg;
            r_e4_bg    <= r_e3_ctx.bg;
        end
    end

    // E5: per-channel blend; n/255 = (n + (n >> 8) + 1) >> 8 for n below 65535.
    function automatic logic [5:0] blend_ch(input logic [5:0] fg, input logic [5:0] bg,
                                           input logic [7:0] a);
        logic [15:0] n;
        logic [15:0] s;
        n = 16'(fg * a) + 16'(bg * (8'd255 - a));
        s = n + (n >> 8) + 16'd1;
        return s[13:8];
    endfunction

    rbn_pkg::t_out_req n_out, r_out;
    logic [5:0] bl_r, bl_g, bl_b;

    always_comb begin
        bl_r = blend_ch({1'b0, r_e4_fg[15:11]}, {1'b0, r_e4_bg[15:11]}, r_e4_alpha);
        bl_g = blend_ch(r_e4_fg[10:5], r_e4_bg[10:5], r_e4_alpha);
        bl_b = blend_ch({1'b0, r_e4_fg[4:0]}, {1'b0, r_e4_bg[4:0]}, r_e4_alpha);
        n_out.pixel_role = r_e4_role;
        if (r_e4_alpha == 8'd0) begin
            n_out.new_pixel    = r_e4_bg;
            n_out.write_enable = 1'b0;
        end else if (r_e4_alpha == 8'd255) begin
            n_out.new_pixel    = r_e4_fg;
            n_out.write_enable = 1'b1;
        end else begin
            n_out.new_pixel    = {bl_r[4:0], bl_g, bl_b[4:0]};
            n_out.write_enable = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NST-1]) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

    a_out_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.pixel_role == rbn_pkg::ROLE_OUT |-> !o_out.write_enable)
        else $error("outside pixel marked for write");

    a_fill_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.pixel_role == rbn_pkg::ROLE_FILL |-> o_out.write_enable)
        else $error("interior pixel not marked for write");

    a_bubble_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[0] |-> !o_stall)
        else $error("input stalled while the first stage is empty");

endmodule
